// File: hdl/slmt_pkg.sv
// Shared types and constants for the segment line minimum tree.
// No dependencies; slmt_line_eval and the core refer to it by scoped names.
`timescale 1ns / 1ps

package slmt_pkg;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 10;
    localparam int CFG_W   = 11;
    localparam int COORD_W = 32;
    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // value of an empty node and of an uncovered query
    localparam logic [ICPT_W-1:0] NO_LINE = 64'd1000000000000000000;

    // insert sequencer phases
    localparam logic [3:0] PH_FEED_FIRST = 4'd3;
    localparam logic [3:0] PH_FEED_LAST  = 4'd8;
    localparam logic [3:0] PH_DECIDE     = 4'd11;
    // query sequencer phases
    localparam logic [3:0] PH_QFEED      = 4'd1;
    localparam logic [3:0] PH_QACC       = 4'd3;

    typedef struct packed {
        logic [SLOPE_W-1:0] slope;
        logic [ICPT_W-1:0]  icpt;
    } line_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VISIT,
        ST_POP,
        ST_EVAL,
        ST_QUERY,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DEC_POP,
        DEC_RIGHT,
        DEC_LEFT,
        DEC_SPLIT
    } dec_t;

endpackage

// File: hdl/slmt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the coordinate table and the node line store. No dependencies.
`timescale 1ns / 1ps

module slmt_ram #(
    parameter int DW    = 32,
    parameter int AW    = 10,
    parameter int DEPTH = 1024
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/slmt_line_eval.sv
// Two-stage line evaluator: slope * coordinate, then + intercept, wrapping at 64 bits.
// Depends on slmt_pkg for field widths.
`timescale 1ns / 1ps

module slmt_line_eval (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [slmt_pkg::SLOPE_W-1:0] slope,
    input  logic [slmt_pkg::COORD_W-1:0] coord,
    input  logic [slmt_pkg::ICPT_W-1:0]  icpt,
    output logic                        out_valid,
    output logic [slmt_pkg::ICPT_W-1:0]  value
);

    logic signed [slmt_pkg::ICPT_W-1:0] prod;
    logic [slmt_pkg::ICPT_W-1:0] prod_reg;
    logic [slmt_pkg::ICPT_W-1:0] icpt_reg;
    logic [slmt_pkg::ICPT_W-1:0] value_reg;
    logic                        v1_reg;
    logic                        v2_reg;

    // 32x32 signed product is exact in 64 bits
    assign prod = $signed(slope) * $signed(coord);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        prod_reg  <= prod;
        icpt_reg  <= icpt;
        value_reg <= prod_reg + icpt_reg;
    end

    assign out_valid = v2_reg;
    assign value     = value_reg;

endmodule

// File: hdl/segment_line_min_tree_core.sv
// Li Chao segment tree over a loaded coordinate table: top level and sequencer.
// Depends on slmt_pkg, slmt_ram and slmt_line_eval.
//
// Usage: the s_ channel carries one operation per beat: load coordinate,
// insert line over an inclusive index range, or query the minimum at one
// index. Only a query produces a beat on the m_ channel (minimum_value, or
// 10^18 when no line covers the index). cfg_data sets points_in_use and is
// written whenever cfg_valid is high (cfg_ready is always high); 0 counts as
// 1 and values above POINTS count as POINTS.
// One item is worked at a time. A load is written to the coordinate table from
// the idle state when its index is below POINTS. A query walks the root-to-leaf
// path, with a node RAM read plus the two-stage evaluator at each level. An
// insert visits each tree node on its split path and runs a compare sequence on
// every covering node it compares at (three coordinate reads through the single
// RAM port, six evaluations through one multiplier), plus a pop state per stack pop.
// After reset the node store is swept to the empty line with s_ready low. If
// m_ready is low, a finished query result is held in the output register and
// the next item is still accepted; a second query result waits until the first
// beat is taken.
`timescale 1ns / 1ps

module segment_line_min_tree_core #(
    parameter int POINTS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [slmt_pkg::OP_W-1:0]     s_operation,
    input  logic [slmt_pkg::IDX_W-1:0]    s_first_index,
    input  logic [slmt_pkg::IDX_W-1:0]    s_last_index,
    input  logic signed [slmt_pkg::COORD_W-1:0] s_coordinate_value,
    input  logic signed [slmt_pkg::SLOPE_W-1:0] s_line_slope,
    input  logic signed [slmt_pkg::ICPT_W-1:0]  s_line_intercept,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [slmt_pkg::ICPT_W-1:0]  m_minimum_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [slmt_pkg::CFG_W-1:0]    cfg_data
);

    localparam int IW      = $clog2(POINTS);
    localparam int NW      = $clog2(2 * POINTS);
    localparam int XW      = ((IW > slmt_pkg::IDX_W) ? IW : slmt_pkg::IDX_W) + 1;
    localparam int SW      = $clog2(IW + 2);
    localparam int SD      = 1 << SW;
    localparam int TOP_RST = ((POINTS < 1024) ? POINTS : 1024) - 1;
    localparam int NDW     = slmt_pkg::SLOPE_W + slmt_pkg::ICPT_W;

    typedef struct packed {
        logic [XW-1:0]   l;
        logic [XW-1:0]   r;
        slmt_pkg::line_t line;
    } frame_t;

    slmt_pkg::state_t state_reg, state_next;
    logic [3:0]       ph_reg;
    logic [XW-1:0]    top_reg;
    logic [XW-1:0]    l_reg, r_reg, x_reg, y_reg;
    slmt_pkg::line_t  line_reg, cur_reg;
    logic [slmt_pkg::COORD_W-1:0] cl_reg, cr_reg, cm_reg;
    logic [slmt_pkg::ICPT_W-1:0]  res_reg [6];
    logic [slmt_pkg::ICPT_W-1:0]  best_reg;
    logic             first_reg;
    frame_t           stk_reg [SD];
    logic [SW:0]      sp_reg;
    logic [SW:0]      sp_dec;
    logic [NW-1:0]    clr_reg;
    logic             m_valid_reg;
    logic [slmt_pkg::ICPT_W-1:0]  m_data_reg;

    // node geometry
    logic [XW:0]   mid_sum;
    logic [XW-1:0] mid, mid1;
    logic [NW-1:0] slot;
    logic          outside, covered, leaf;

    // memories and evaluator
    logic           node_we;
    logic [NW-1:0]  node_waddr, node_raddr;
    logic [NDW-1:0] node_wdata, node_rdata;
    slmt_pkg::line_t node_line;
    logic           coord_we;
    logic [IW-1:0]  coord_waddr, coord_raddr;
    logic [slmt_pkg::COORD_W-1:0] coord_rdata;
    logic           ev_in_valid, ev_out_valid;
    logic [slmt_pkg::SLOPE_W-1:0] ev_slope;
    logic [slmt_pkg::COORD_W-1:0] ev_coord;
    logic [slmt_pkg::ICPT_W-1:0]  ev_icpt, ev_value;

    logic             accept;
    slmt_pkg::dec_t   dec;
    logic             dec_write, dec_use_cur;
    logic             out_load;
    logic [slmt_pkg::CFG_W-1:0] cfg_dec;

    assign mid_sum = {1'b0, l_reg} + {1'b0, r_reg};
    assign mid     = mid_sum[XW:1];
    assign mid1    = mid + 1'b1;
    assign slot    = NW'(mid_sum | (XW + 1)'(l_reg != r_reg));
    assign outside = (l_reg > y_reg) || (r_reg < x_reg);
    assign covered = (x_reg <= l_reg) && (r_reg <= y_reg);
    assign leaf    = (l_reg == r_reg);
    assign sp_dec  = sp_reg - 1'b1;
    assign node_line = node_rdata;
    assign accept  = s_valid && s_ready;
    assign out_load = (state_reg == slmt_pkg::ST_DONE) && (!m_valid_reg || m_ready);
    assign cfg_dec = cfg_data - 1'b1;

    slmt_ram #(
        .DW(NDW), .AW(NW), .DEPTH(2 * POINTS)
    ) u_node_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rdata)
    );

    slmt_ram #(
        .DW(slmt_pkg::COORD_W), .AW(IW), .DEPTH(POINTS)
    ) u_coord_ram (
        .aclk(aclk), .we(coord_we), .waddr(coord_waddr),
        .wdata(s_coordinate_value), .raddr(coord_raddr), .rdata(coord_rdata)
    );

    slmt_line_eval u_eval (
        .aclk(aclk), .aresetn(aresetn), .in_valid(ev_in_valid),
        .slope(ev_slope), .coord(ev_coord), .icpt(ev_icpt),
        .out_valid(ev_out_valid), .value(ev_value)
    );

    // compare stored line (c) with new line (v) at left, mid and right ends
    always_comb begin
        logic lge, lle, rge, rle, mge, mle;
        lge = $signed(res_reg[0]) >= $signed(res_reg[1]);
        lle = $signed(res_reg[0]) <= $signed(res_reg[1]);
        rge = $signed(res_reg[2]) >= $signed(res_reg[3]);
        rle = $signed(res_reg[2]) <= $signed(res_reg[3]);
        mge = $signed(res_reg[4]) >= $signed(res_reg[5]);
        mle = $signed(res_reg[4]) <= $signed(res_reg[5]);
        dec         = slmt_pkg::DEC_SPLIT;
        dec_write   = 1'b0;
        dec_use_cur = 1'b0;
        priority if (lge && rge) begin
            dec       = slmt_pkg::DEC_POP;
            dec_write = 1'b1;
        end else if (lle && rle) begin
            dec = slmt_pkg::DEC_POP;
        end else if (leaf) begin
            dec = slmt_pkg::DEC_POP;
        end else if (lge && mge) begin
            dec         = slmt_pkg::DEC_RIGHT;
            dec_write   = 1'b1;
            dec_use_cur = 1'b1;
        end else if (lle && mle) begin
            dec = slmt_pkg::DEC_RIGHT;
        end else if (mge && rge) begin
            dec         = slmt_pkg::DEC_LEFT;
            dec_write   = 1'b1;
            dec_use_cur = 1'b1;
        end else if (mle && rle) begin
            dec = slmt_pkg::DEC_LEFT;
        end else begin
            dec = slmt_pkg::DEC_SPLIT;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            slmt_pkg::ST_CLEAR: begin
                if (clr_reg == NW'(2 * POINTS - 1)) state_next = slmt_pkg::ST_IDLE;
            end
            slmt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == slmt_pkg::OP_INSERT && s_first_index <= s_last_index) begin
                        state_next = slmt_pkg::ST_VISIT;
                    end else if (s_operation == slmt_pkg::OP_QUERY) begin
                        state_next = (XW'(s_first_index) > top_reg) ? slmt_pkg::ST_DONE
                                                                   : slmt_pkg::ST_QUERY;
                    end
                end
            end
            slmt_pkg::ST_VISIT: begin
                if (outside) state_next = slmt_pkg::ST_POP;
                else if (covered) state_next = slmt_pkg::ST_EVAL;
                else if (leaf) state_next = slmt_pkg::ST_POP;
            end
            slmt_pkg::ST_POP: begin
                state_next = (sp_reg == '0) ? slmt_pkg::ST_IDLE : slmt_pkg::ST_VISIT;
            end
            slmt_pkg::ST_EVAL: begin
                if (ph_reg == slmt_pkg::PH_DECIDE) begin
                    state_next = (dec == slmt_pkg::DEC_POP) ? slmt_pkg::ST_POP
                                                            : slmt_pkg::ST_VISIT;
                end
            end
            slmt_pkg::ST_QUERY: begin
                if (ph_reg == slmt_pkg::PH_QACC && leaf) state_next = slmt_pkg::ST_DONE;
            end
            slmt_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = slmt_pkg::ST_IDLE;
            end
            default: state_next = slmt_pkg::ST_IDLE;
        endcase
    end

    // memory, evaluator and handshake controls
    always_comb begin
        s_ready     = 1'b0;
        node_we     = 1'b0;
        node_waddr  = slot;
        node_wdata  = line_reg;
        node_raddr  = slot;
        coord_we    = 1'b0;
        coord_waddr = IW'(s_first_index);
        coord_raddr = IW'(mid);
        ev_in_valid = 1'b0;
        ev_slope    = cur_reg.slope;
        ev_coord    = cl_reg;
        ev_icpt     = cur_reg.icpt;
        unique case (state_reg)
            slmt_pkg::ST_CLEAR: begin
                node_we    = 1'b1;
                node_waddr = clr_reg;
                node_wdata = {{slmt_pkg::SLOPE_W{1'b0}}, slmt_pkg::NO_LINE};
            end
            slmt_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                coord_we = s_valid && (s_operation == slmt_pkg::OP_LOAD)
                           && (32'(s_first_index) < 32'(POINTS));
            end
            slmt_pkg::ST_EVAL: begin
                if (ph_reg == 4'd0) coord_raddr = IW'(l_reg);
                else if (ph_reg == 4'd1) coord_raddr = IW'(r_reg);
                if (ph_reg >= slmt_pkg::PH_FEED_FIRST && ph_reg <= slmt_pkg::PH_FEED_LAST) begin
                    ev_in_valid = 1'b1;
                end
                // feed order: stored@l, new@l, stored@r, new@r, stored@m, new@m
                if (ph_reg[0]) begin
                    ev_slope = cur_reg.slope;
                    ev_icpt  = cur_reg.icpt;
                end else begin
                    ev_slope = line_reg.slope;
                    ev_icpt  = line_reg.icpt;
                end
                if (ph_reg <= 4'd4) ev_coord = cl_reg;
                else if (ph_reg <= 4'd6) ev_coord = cr_reg;
                else ev_coord = cm_reg;
                node_we = (ph_reg == slmt_pkg::PH_DECIDE) && dec_write;
            end
            slmt_pkg::ST_QUERY: begin
                coord_raddr = IW'(x_reg);
                ev_in_valid = (ph_reg == slmt_pkg::PH_QFEED);
                ev_slope    = node_line.slope;
                ev_coord    = coord_rdata;
                ev_icpt     = node_line.icpt;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slmt_pkg::ST_CLEAR;
            clr_reg     <= '0;
            ph_reg      <= '0;
            sp_reg      <= '0;
            top_reg     <= XW'(TOP_RST);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == slmt_pkg::ST_CLEAR) clr_reg <= clr_reg + 1'b1;

            if (cfg_valid) begin
                if (cfg_data == '0) top_reg <= '0;
                else if (32'(cfg_data) > 32'(POINTS)) top_reg <= XW'(POINTS - 1);
                else top_reg <= XW'(cfg_dec);
            end

            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                slmt_pkg::ST_IDLE: begin
                    ph_reg <= '0;
                    sp_reg <= '0;
                end
                slmt_pkg::ST_VISIT: begin
                    ph_reg <= '0;
                    if (!outside && !covered && !leaf) sp_reg <= sp_reg + 1'b1;
                end
                slmt_pkg::ST_POP: begin
                    if (sp_reg != '0) sp_reg <= sp_dec;
                end
                slmt_pkg::ST_EVAL: begin
                    ph_reg <= ph_reg + 1'b1;
                    if (ph_reg == slmt_pkg::PH_DECIDE && dec == slmt_pkg::DEC_SPLIT) begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                end
                slmt_pkg::ST_QUERY: begin
                    if (ph_reg == slmt_pkg::PH_QACC) ph_reg <= '0;
                    else ph_reg <= ph_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (ev_out_valid && state_reg == slmt_pkg::ST_EVAL) begin
            for (int i = 0; i < 5; i++) res_reg[i] <= res_reg[i + 1];
            res_reg[5] <= ev_value;
        end
        if (out_load) m_data_reg <= best_reg;

        unique case (state_reg)
            slmt_pkg::ST_IDLE: begin
                if (accept) begin
                    x_reg     <= XW'(s_first_index);
                    y_reg     <= XW'(s_last_index);
                    l_reg     <= '0;
                    r_reg     <= top_reg;
                    line_reg  <= {s_line_slope, s_line_intercept};
                    first_reg <= 1'b1;
                    best_reg  <= slmt_pkg::NO_LINE;
                end
            end
            slmt_pkg::ST_VISIT: begin
                if (!outside && !covered && !leaf) begin
                    stk_reg[sp_reg[SW-1:0]] <= '{l: mid1, r: r_reg, line: line_reg};
                    r_reg <= mid;
                end
            end
            slmt_pkg::ST_POP: begin
                if (sp_reg != '0) begin
                    l_reg    <= stk_reg[sp_dec[SW-1:0]].l;
                    r_reg    <= stk_reg[sp_dec[SW-1:0]].r;
                    line_reg <= stk_reg[sp_dec[SW-1:0]].line;
                end
            end
            slmt_pkg::ST_EVAL: begin
                if (ph_reg == 4'd1) begin
                    cur_reg <= node_line;
                    cl_reg  <= coord_rdata;
                end
                if (ph_reg == 4'd2) cr_reg <= coord_rdata;
                if (ph_reg == 4'd3) cm_reg <= coord_rdata;
                if (ph_reg == slmt_pkg::PH_DECIDE) begin
                    unique case (dec)
                        slmt_pkg::DEC_RIGHT: begin
                            l_reg <= mid1;
                            if (dec_use_cur) line_reg <= cur_reg;
                        end
                        slmt_pkg::DEC_LEFT: begin
                            r_reg <= mid;
                            if (dec_use_cur) line_reg <= cur_reg;
                        end
                        slmt_pkg::DEC_SPLIT: begin
                            stk_reg[sp_reg[SW-1:0]] <= '{l: mid1, r: r_reg, line: line_reg};
                            r_reg <= mid;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            slmt_pkg::ST_QUERY: begin
                if (ph_reg == slmt_pkg::PH_QACC) begin
                    if (first_reg || $signed(ev_value) < $signed(best_reg)) best_reg <= ev_value;
                    first_reg <= 1'b0;
                    if (!leaf) begin
                        if (x_reg <= mid) r_reg <= mid;
                        else l_reg <= mid1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_minimum_value = m_data_reg;
    assign cfg_ready       = 1'b1;

endmodule
